@@ src/psola_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psola_pkg
// Shared types, constants and the window polynomial coefficients of the
// PSOLA pitch shifter.
// ----------------------------------------------------------------------------
package psola_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF   = 4096;
  localparam int unsigned START_OFFSET_DEF   = 4096;
  localparam int unsigned MAX_HALF_GRAIN_DEF = 800;

  // divider geometry: dividend covers k<<30, tap<<12 and period<<22
  localparam int DIV_W = 44;
  localparam int DVS_W = 16;
  localparam int MUL_W = 32;

  // configuration port
  localparam int   PADDR_W     = 3;
  localparam logic REG_LATENCY = 1'b0;   // word index of latency_samples

  localparam logic [11:0] LAT_RESET    = 12'd2048;
  localparam logic [15:0] PERIOD_RESET = 16'd14080;  // 220.0 in Q10.6
  localparam logic [15:0] PERIOD_MIN   = 16'd2560;   // 40.0 in Q10.6
  localparam logic [15:0] RATIO_ONE    = 16'd4096;
  localparam logic [15:0] RATIO_MIN    = 16'd1024;
  localparam logic [15:0] RATIO_MAX    = 16'd16384;
  localparam logic [31:0] POLY_LEAD    = 32'd27061;

  // reciprocals for the constant divisions, exact over the operand ranges
  localparam logic [31:0] RECIP_100    = 32'd21474837;  // ceil(2^31 / 100)
  localparam logic [31:0] RECIP_10     = 32'd26215;     // ceil(2^18 / 10)

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CLAMP, S_CLAMP_WAIT, S_PREP, S_LOOP,
    S_SMOOTH, S_SMOOTH_WAIT, S_TGT, S_MARK, S_GEOM,
    S_WDIV, S_WDIV_WAIT, S_WSQ, S_WU2, S_WPOLY, S_WT, S_WC,
    S_TAP_RD, S_TAP_MUL, S_TAP_SCALE, S_TAP_DIV, S_TAP_ACC,
    S_CENTRE, S_CENTRE_WAIT, S_OUT_RD, S_OUT_WR
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  // Horner coefficients of the quarter cosine, Q30
  function automatic logic [31:0] poly_coef(input logic [1:0] idx);
    logic [31:0] c;
    case (idx)
      2'd0:    c = 32'd987048;
      2'd1:    c = 32'd22401992;
      2'd2:    c = 32'd272375561;
      default: c = 32'd1324675879;
    endcase
    return c;
  endfunction

endpackage

@@ src/psola_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psola_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module psola_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/psola_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psola_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psola_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psola_pkg::div_req_t  req,
  output psola_pkg::div_rsp_t  rsp
);
  import psola_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   q_r, q_nxt;
  logic [DVS_W:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W+1:0]   diff;

  assign rem_sh = {rem_r[DVS_W-1:0], q_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W - 1);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[DVS_W+1]) begin
        rem_nxt = diff[DVS_W:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

@@ src/psola_pitch_shifter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psola_pitch_shifter
// PSOLA pitch shifter: per input sample, places Hann-windowed grains into an
// overlap store and returns one delayed, saturated output sample.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  in_      | in_valid / in_ready     | sample_in, pitch_period, voiced, target_ratio
//  out_     | out_valid / out_ready   | sample_out
//  cfg_     | APB, pready tied high   | latency_samples at byte address 0
//
//  A voiced sample first clamps its period by reciprocal multiply. A grain
//  walks the analysis marks, then visits every tap, each through a divide
//  when the ratio is above 1.0; when the half length changes, the window
//  table is refilled first, one entry at a time.
//  Taps and window entries are 2T+1 each.
//  After reset a clearing pass zeroes both stores; in_ready stays low
//  meanwhile. A held output stalls the final step only.
// ----------------------------------------------------------------------------
module psola_pitch_shifter #(
  parameter int unsigned BUFFER_DEPTH   = psola_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned START_OFFSET   = psola_pkg::START_OFFSET_DEF,
  parameter int unsigned MAX_HALF_GRAIN = psola_pkg::MAX_HALF_GRAIN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_sample_in,
  input  logic [15:0]                    in_pitch_period,
  input  logic                           in_voiced,
  input  logic [14:0]                    in_target_ratio,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_sample_out,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [psola_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import psola_pkg::*;

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int WDEPTH = 2 * MAX_HALF_GRAIN + 1;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int TW     = $clog2(MAX_HALF_GRAIN + 1);
  localparam logic [16:0] PER_CAP  = 17'(MAX_HALF_GRAIN * 64);
  localparam logic [55:0] START56  = 56'(START_OFFSET) << 16;
  localparam logic [39:0] START40  = 40'(START_OFFSET);
  localparam logic [10:0] T_MIN    = 11'd16;
  localparam logic [10:0] T_MAX    = 11'(MAX_HALF_GRAIN);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [11:0]       lat_r, lat_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [39:0]       opos_r, opos_nxt;
  logic [55:0]       ngc_r, ngc_nxt;
  logic [55:0]       mark_r, mark_nxt;
  logic [15:0]       per_r, per_nxt;
  logic [15:0]       ratio_r, ratio_nxt;
  logic [15:0]       tgt_r, tgt_nxt;
  logic              voiced_r, voiced_nxt;
  logic [TW-1:0]     whl_r, whl_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [15:0]       pin_r, pin_nxt;
  logic [55:0]       limit_r, limit_nxt;
  logic [28:0]       off_r, off_nxt;
  logic [55:0]       target_r, target_nxt;
  logic [AW-1:0]     mbase_r, mbase_nxt;
  logic [AW-1:0]     obase_r, obase_nxt;
  logic [WAW-1:0]    j_r, j_nxt;
  logic [1:0]        poly_r, poly_nxt;
  logic [30:0]       u_r, u_nxt;
  logic [30:0]       u2_r, u2_nxt;
  logic [63:0]       mul_r;
  logic              sign_r, sign_nxt;
  logic [30:0]       mag_r, mag_nxt;
  logic [15:0]       out_r, out_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              ring_we, ring_re;
  logic [AW-1:0]     ring_waddr;
  logic [15:0]       ring_wdata, ring_rdata;
  logic              ov_we, ov_re;
  logic [AW-1:0]     ov_waddr, ov_raddr;
  logic [31:0]       ov_wdata, ov_rdata;
  logic              win_we, win_re;
  logic [15:0]       win_wdata, win_rdata;

  // helpers
  logic [AW-1:0]     j_ring, tap_ring_addr, tap_ov_addr;
  logic [WAW-1:0]    two_t, t_w, k_w;
  logic [16:0]       hi_q, pin_c;
  logic [15:0]       per_clamped;
  logic [16:0]       tr_sum;
  logic [10:0]       t_raw, t_new;
  logic [AW+15:0]    msum, osum;
  logic [55:0]       loop_diff, mark_diff;
  logic [16:0]       goal, d_s, d_mag;
  logic [31:0]       pval, tt, cval;
  logic [15:0]       xmag;
  logic [31:0]       rnd, tap_add;
  logic [63:0]       win_round;
  logic              cfg_we;

  assign j_ring        = AW'(j_r);
  assign tap_ring_addr = mbase_r + j_ring;
  assign tap_ov_addr   = obase_r + j_ring;
  assign t_w           = WAW'(whl_r);
  assign two_t         = WAW'({whl_r, 1'b0});
  assign k_w           = (j_r >= t_w) ? (j_r - t_w) : (t_w - j_r);

  // period cap lat_r * 24.32, floored: bits [47:31] of the product with the reciprocal
  assign hi_q        = (mul_r[47:31] > PER_CAP) ? PER_CAP : mul_r[47:31];
  assign pin_c       = ({1'b0, pin_r} > hi_q) ? hi_q : {1'b0, pin_r};
  assign per_clamped = (pin_c < {1'b0, PERIOD_MIN}) ? PERIOD_MIN : pin_c[15:0];

  assign tr_sum = {1'b0, per_r} + 17'd32;
  assign t_raw  = tr_sum[16:6];
  assign t_new  = (t_raw < T_MIN) ? T_MIN : ((t_raw > T_MAX) ? T_MAX : t_raw);

  assign msum = mark_r[AW+15:0] + (AW+16)'(32768);
  assign osum = ngc_r[AW+15:0] + (AW+16)'(32768);

  assign loop_diff = limit_r - ngc_r;
  assign mark_diff = target_r - mark_r;

  assign goal  = voiced_r ? {1'b0, tgt_r} : {1'b0, RATIO_ONE};
  assign d_s   = goal - {1'b0, ratio_r};
  assign d_mag = d_s[16] ? (17'd0 - d_s) : d_s;

  assign pval = poly_coef(poly_r) - mul_r[61:30];
  assign tt   = mul_r[61:30];
  assign cval = (tt >= 32'h4000_0000) ? 32'd0 : (32'h4000_0000 - tt);
  assign win_round = mul_r + 64'h0000_1000_0000_0000;
  assign win_wdata = win_round[60:45];

  assign xmag    = ring_rdata[15] ? (16'd0 - ring_rdata) : ring_rdata;
  assign rnd     = (32'(mag_r) + 32'd16384) >> 15;
  assign tap_add = sign_r ? (32'd0 - rnd) : rnd;

  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_LATENCY);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_LATENCY) ? {20'd0, lat_r} : 32'd0;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    lat_nxt       = cfg_we ? cfg_pwdata[11:0] : lat_r;
    wpos_nxt      = wpos_r;
    opos_nxt      = opos_r;
    ngc_nxt       = ngc_r;
    mark_nxt      = mark_r;
    per_nxt       = per_r;
    ratio_nxt     = ratio_r;
    tgt_nxt       = tgt_r;
    voiced_nxt    = voiced_r;
    whl_nxt       = whl_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    pin_nxt       = pin_r;
    limit_nxt     = limit_r;
    off_nxt       = off_r;
    target_nxt    = target_r;
    mbase_nxt     = mbase_r;
    obase_nxt     = obase_r;
    j_nxt         = j_r;
    poly_nxt      = poly_r;
    u_nxt         = u_r;
    u2_nxt        = u2_r;
    sign_nxt      = sign_r;
    mag_nxt       = mag_r;
    out_nxt       = out_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req       = '0;
    ring_we       = 1'b0;
    ring_waddr    = wpos_r;
    ring_wdata    = in_sample_in;
    ring_re       = 1'b0;
    ov_we         = 1'b0;
    ov_waddr      = tap_ov_addr;
    ov_wdata      = ov_rdata + tap_add;
    ov_re         = 1'b0;
    ov_raddr      = tap_ov_addr;
    win_we        = 1'b0;
    win_re        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_r;
        ring_wdata = '0;
        ov_we      = 1'b1;
        ov_waddr   = clr_r;
        ov_wdata   = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ring_we    = 1'b1;
          wpos_nxt   = wpos_r + 1'b1;
          voiced_nxt = in_voiced;
          pin_nxt    = in_pitch_period;
          if ({1'b0, in_target_ratio} < RATIO_MIN)      tgt_nxt = RATIO_MIN;
          else if ({1'b0, in_target_ratio} > RATIO_MAX) tgt_nxt = RATIO_MAX;
          else                                          tgt_nxt = {1'b0, in_target_ratio};
          state_nxt = in_voiced ? S_CLAMP : S_PREP;
        end
      end
      S_CLAMP: begin
        mul_a     = 32'(24'(lat_r) * 24'd2432);
        mul_b     = RECIP_100;
        state_nxt = S_CLAMP_WAIT;
      end
      S_CLAMP_WAIT: begin
        per_nxt   = per_clamped;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        limit_nxt = {opos_r, 16'd0} + (56'(per_r) << 10);
        off_nxt   = (29'(lat_r) << 16) + (29'(per_r) << 9);
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        state_nxt = loop_diff[55] ? S_OUT_RD : S_SMOOTH;
      end
      S_SMOOTH: begin
        // (|d| + 5) / 10 by reciprocal, shifted down by 18
        sign_nxt  = d_s[16];
        mul_a     = 32'(d_mag + 17'd5);
        mul_b     = RECIP_10;
        state_nxt = S_SMOOTH_WAIT;
      end
      S_SMOOTH_WAIT: begin
        ratio_nxt = sign_r ? (ratio_r - mul_r[33:18])
                           : (ratio_r + mul_r[33:18]);
        state_nxt = S_TGT;
      end
      S_TGT: begin
        target_nxt = ngc_r - 56'(off_r);
        state_nxt  = S_MARK;
      end
      S_MARK: begin
        // walk the analysis grid up to the first mark at or past the delayed centre
        if (mark_diff != '0 && !mark_diff[55]) begin
          mark_nxt = mark_r + (56'(per_r) << 10);
        end else begin
          state_nxt = S_GEOM;
        end
      end
      S_GEOM: begin
        mbase_nxt = msum[AW+15:16] - AW'(t_new);
        obase_nxt = osum[AW+15:16] - AW'(t_new);
        whl_nxt   = TW'(t_new);
        j_nxt     = '0;
        state_nxt = (TW'(t_new) != whl_r) ? S_WDIV : S_TAP_RD;
      end
      S_WDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(k_w) << 30;
        div_req.divisor  = DVS_W'(whl_r);
        state_nxt        = S_WDIV_WAIT;
      end
      S_WDIV_WAIT: begin
        if (div_rsp.done) begin
          u_nxt     = div_rsp.quotient[30:0];
          state_nxt = S_WSQ;
        end
      end
      S_WSQ: begin
        mul_a     = 32'(u_r);
        mul_b     = 32'(u_r);
        state_nxt = S_WU2;
      end
      S_WU2: begin
        u2_nxt    = mul_r[60:30];
        mul_a     = POLY_LEAD;
        mul_b     = 32'(mul_r[60:30]);
        poly_nxt  = '0;
        state_nxt = S_WPOLY;
      end
      S_WPOLY: begin
        mul_a    = pval;
        mul_b    = 32'(u2_r);
        poly_nxt = poly_r + 1'b1;
        if (poly_r == 2'd3) state_nxt = S_WT;
      end
      S_WT: begin
        mul_a     = cval;
        mul_b     = cval;
        state_nxt = S_WC;
      end
      S_WC: begin
        win_we = 1'b1;
        if (j_r == two_t) begin
          j_nxt     = '0;
          state_nxt = S_TAP_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_WDIV;
        end
      end
      S_TAP_RD: begin
        ring_re   = 1'b1;
        win_re    = 1'b1;
        ov_re     = 1'b1;
        state_nxt = S_TAP_MUL;
      end
      S_TAP_MUL: begin
        sign_nxt  = ring_rdata[15];
        mul_a     = 32'(win_rdata);
        mul_b     = 32'(xmag);
        state_nxt = S_TAP_SCALE;
      end
      S_TAP_SCALE: begin
        if (ratio_r > RATIO_ONE) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(mul_r[30:0]) << 12;
          div_req.divisor  = ratio_r;
          state_nxt        = S_TAP_DIV;
        end else begin
          mag_nxt   = mul_r[30:0];
          state_nxt = S_TAP_ACC;
        end
      end
      S_TAP_DIV: begin
        if (div_rsp.done) begin
          mag_nxt   = div_rsp.quotient[30:0];
          state_nxt = S_TAP_ACC;
        end
      end
      S_TAP_ACC: begin
        ov_we = 1'b1;
        if (j_r == two_t) begin
          state_nxt = S_CENTRE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_TAP_RD;
        end
      end
      S_CENTRE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(per_r) << 22;
        div_req.divisor  = (ratio_r == '0) ? 16'd1 : ratio_r;
        state_nxt        = S_CENTRE_WAIT;
      end
      S_CENTRE_WAIT: begin
        if (div_rsp.done) begin
          ngc_nxt   = ngc_r + 56'(div_rsp.quotient);
          state_nxt = S_LOOP;
        end
      end
      S_OUT_RD: begin
        ov_re     = 1'b1;
        ov_raddr  = opos_r[AW-1:0];
        state_nxt = S_OUT_WR;
      end
      S_OUT_WR: begin
        ov_waddr = opos_r[AW-1:0];
        ov_wdata = '0;
        if (!out_valid_r || out_ready) begin
          ov_we         = 1'b1;
          out_valid_nxt = 1'b1;
          if ($signed(ov_rdata) > 32'sd32767)       out_nxt = 16'h7FFF;
          else if ($signed(ov_rdata) < -32'sd32768) out_nxt = 16'h8000;
          else                                      out_nxt = ov_rdata[15:0];
          opos_nxt  = opos_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      lat_r       <= LAT_RESET;
      wpos_r      <= AW'(START_OFFSET);
      opos_r      <= START40;
      ngc_r       <= START56;
      mark_r      <= START56;
      per_r       <= PERIOD_RESET;
      ratio_r     <= RATIO_ONE;
      tgt_r       <= RATIO_ONE;
      voiced_r    <= 1'b0;
      whl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      lat_r       <= lat_nxt;
      wpos_r      <= wpos_nxt;
      opos_r      <= opos_nxt;
      ngc_r       <= ngc_nxt;
      mark_r      <= mark_nxt;
      per_r       <= per_nxt;
      ratio_r     <= ratio_nxt;
      tgt_r       <= tgt_nxt;
      voiced_r    <= voiced_nxt;
      whl_r       <= whl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_r    <= pin_nxt;
    limit_r  <= limit_nxt;
    off_r    <= off_nxt;
    target_r <= target_nxt;
    mbase_r  <= mbase_nxt;
    obase_r  <= obase_nxt;
    j_r      <= j_nxt;
    poly_r   <= poly_nxt;
    u_r      <= u_nxt;
    u2_r     <= u2_nxt;
    mul_r    <= mul_a * mul_b;
    sign_r   <= sign_nxt;
    mag_r    <= mag_nxt;
    out_r    <= out_nxt;
  end

  psola_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  psola_ram #(.WIDTH(16), .DEPTH(BUFFER_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (tap_ring_addr),
    .rdata (ring_rdata)
  );

  psola_ram #(.WIDTH(32), .DEPTH(BUFFER_DEPTH)) u_ovl (
    .clk   (clk),
    .we    (ov_we),
    .waddr (ov_waddr),
    .wdata (ov_wdata),
    .re    (ov_re),
    .raddr (ov_raddr),
    .rdata (ov_rdata)
  );

  psola_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_win (
    .clk   (clk),
    .we    (win_we),
    .waddr (j_r),
    .wdata (win_wdata),
    .re    (win_re),
    .raddr (j_r),
    .rdata (win_rdata)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // new result only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT_WR))
    else $error("result raised outside output step");

  // shared divider is never restarted mid-operation
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // window writes stay inside the current table
  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    win_we |-> (j_r <= two_t) && (whl_r != '0))
    else $error("window write out of range");

  // taps never run without a filled table
  a_tap_tbl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAP_RD) |-> (whl_r != '0))
    else $error("tap read before window fill");

endmodule

@@ bench/tb_psola_pitch_shifter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_psola_pitch_shifter
// Self-checking bench for the PSOLA pitch shifter. A bit-exact predictor of
// the grain placement and overlap-add runs alongside the block. Each output
// is compared with the oldest predicted sample. Stimulus covers field
// extremes, several latency settings and random sequences under varied
// flow control.
// ----------------------------------------------------------------------------
module tb_psola_pitch_shifter;
  import psola_pkg::*;

  localparam int RING      = BUFFER_DEPTH_DEF;
  localparam int HALF_MAX  = MAX_HALF_GRAIN_DEF;
  localparam longint unsigned MASK40 = (64'd1 << 40) - 1;
  localparam longint unsigned MASK56 = (64'd1 << 56) - 1;
  localparam longint unsigned BIT55  = 64'd1 << 55;
  localparam longint unsigned CYCLE_LIMIT = 30_000_000;
  localparam logic [PADDR_W-1:0] LAT_ADDR    = PADDR_W'(REG_LATENCY) << 2;
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = LAT_ADDR + PADDR_W'(4);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample_in = '0;
  logic [15:0] in_pitch_period = '0;
  logic in_voiced = 1'b0;
  logic [14:0] in_target_ratio = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_sample_out;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  psola_pitch_shifter dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  shortint         ring_mem [RING];
  int unsigned     ola_mem [RING];
  int unsigned     win_mem [2*HALF_MAX+1];
  int unsigned     win_half;
  longint unsigned wr_pos, rd_pos, grain_ctr, mark_pos;
  int unsigned     period_q6, ratio_sm, ratio_goal, lat_cfg;
  bit              voiced_q;

  logic signed [15:0] expected_out[$];
  int  mismatch_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  longint unsigned cycle_count = 0;

  function automatic longint unsigned quarter_cosine(int unsigned num, int unsigned den);
    longint unsigned u, u2, p, t;
    u  = (longint'(num) << 30) / den;
    u2 = (u * u) >> 30;
    p  = 64'd987048 - ((64'd27061 * u2) >> 30);
    p  = 64'd22401992 - ((p * u2) >> 30);
    p  = 64'd272375561 - ((p * u2) >> 30);
    p  = 64'd1324675879 - ((p * u2) >> 30);
    t  = (p * u2) >> 30;
    return (t >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - t;
  endfunction

  task automatic refill_window(int unsigned t);
    int unsigned k;
    longint unsigned c;
    if (t == win_half) return;
    win_half = t;
    for (int unsigned j = 0; j <= 2*t; j++) begin
      k = (j >= t) ? j - t : t - j;
      c = quarter_cosine(k, t);
      win_mem[j] = int'((c * c + (64'd1 << 44)) >> 45);
    end
  endtask

  function automatic bit ahead56(longint unsigned d);
    d &= MASK56;
    return d != 0 && (d & BIT55) == 0;
  endfunction

  task automatic lay_grain(longint unsigned c);
    longint unsigned tgt, m, oc, idx;
    int unsigned t;
    longint signed w, x, prod, add;
    tgt = (c - (longint'(lat_cfg) << 16) - (longint'(period_q6) << 9)) & MASK56;
    while (ahead56(tgt - mark_pos))
      mark_pos = (mark_pos + (longint'(period_q6) << 10)) & MASK56;
    m  = (mark_pos + 64'h8000) >> 16;
    oc = (c + 64'h8000) >> 16;
    t  = (period_q6 + 32) >> 6;
    if (t < 16) t = 16;
    if (t > HALF_MAX) t = HALF_MAX;
    refill_window(t);
    for (int k = -int'(t); k <= int'(t); k++) begin
      w = win_mem[k + int'(t)];
      x = ring_mem[(m + longint'(k)) & (RING - 1)];
      prod = w * x;
      if (ratio_sm > RATIO_ONE) prod = prod * 4096 / longint'(ratio_sm);
      add = (prod >= 0) ? (prod + 16384) / 32768 : -((-prod + 16384) / 32768);
      idx = (oc + longint'(k)) & (RING - 1);
      ola_mem[idx] = ola_mem[idx] + int'(add);
    end
  endtask

  task automatic predict_sample(logic signed [15:0] s, logic [15:0] p, logic v,
                                logic [14:0] r);
    int unsigned hi, pc, dv;
    int goal, d, st;
    longint unsigned lim, idx;
    longint signed val;
    voiced_q = v;
    if (v) begin
      hi = lat_cfg * 2432 / 100;
      if (hi > HALF_MAX * 64) hi = HALF_MAX * 64;
      pc = p;
      if (pc > hi) pc = hi;
      if (pc < PERIOD_MIN) pc = PERIOD_MIN;
      period_q6 = pc;
    end
    ratio_goal = (r < RATIO_MIN) ? RATIO_MIN : ((r > RATIO_MAX) ? RATIO_MAX : r);
    ring_mem[wr_pos & (RING - 1)] = s;
    wr_pos = (wr_pos + 1) & MASK40;
    lim = ((rd_pos << 16) + (longint'(period_q6) << 10)) & MASK56;
    while (((lim - grain_ctr) & BIT55) == 0) begin
      goal = voiced_q ? int'(ratio_goal) : int'(RATIO_ONE);
      d = goal - int'(ratio_sm);
      st = (d >= 0) ? (d + 5) / 10 : -((-d + 5) / 10);
      ratio_sm = int'(ratio_sm) + st;
      lay_grain(grain_ctr);
      dv = (ratio_sm != 0) ? ratio_sm : 1;
      grain_ctr = (grain_ctr + ((longint'(period_q6) << 22) / dv)) & MASK56;
    end
    idx = rd_pos & (RING - 1);
    val = longint'(signed'(ola_mem[idx]));
    ola_mem[idx] = 0;
    rd_pos = (rd_pos + 1) & MASK40;
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    expected_out.push_back(val[15:0]);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0)
        report_mismatch("unexpected sample_out", out_sample_out, 0);
      else if (out_sample_out !== expected_out[0])
        report_mismatch("sample_out", out_sample_out, expected_out.pop_front());
      else
        void'(expected_out.pop_front());
    end
  end

  // receiver: long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(logic signed [15:0] s, logic [15:0] p, logic v,
                              logic [14:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_in <= s;
    in_pitch_period <= p;
    in_voiced <= v;
    in_target_ratio <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(s, p, v, r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_latency(int unsigned lat);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, LAT_ADDR, lat, rd);
    lat_cfg = lat & 12'hFFF;
    apb_access(1'b0, LAT_ADDR, '0, rd);
    if (rd[11:0] !== lat_cfg[11:0]) report_mismatch("latency readback", rd[11:0], lat_cfg);
  endtask

  task automatic random_run(int n);
    logic [15:0] base_p;
    logic [14:0] r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) base_p = 16'($urandom_range(PERIOD_MIN, 16'd12800));
      case ($urandom_range(9))
        0: send_request(16'($urandom), 16'($urandom), 1'b0, 15'($urandom));   // noise
        1: send_request(16'($urandom), base_p, 1'b0, 15'($urandom));
        default: begin
          r = ($urandom_range(9) < 7) ? 15'($urandom_range(RATIO_MIN, RATIO_ONE))
                                      : 15'($urandom_range(RATIO_ONE, RATIO_MAX));
          send_request(16'($urandom), base_p, 1'b1, r);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    logic [31:0] rd;
    send_request(16'sh7FFF, 16'd14080, 1'b1, 15'd4096);
    send_request(-16'sh8000, 16'd0, 1'b1, 15'd0);          // period below minimum
    send_request(16'sh7FFF, 16'hFFFF, 1'b1, 15'h7FFF);    // period capped, ratio max
    send_request(16'sh0000, 16'hFFFF, 1'b0, 15'd1024);
    send_request(-16'sh0001, 16'd2560, 1'b1, 15'd1023);
    send_request(16'sh0001, 16'd2561, 1'b1, 15'd16384);
    send_request(16'sh5555, 16'h5555, 1'b1, 15'h2AAA);
    send_request(-16'sh2AAB, 16'hAAAA, 1'b0, 15'h5555);
    for (int i = 0; i < 12; i++)
      send_request((i & 1) ? 16'sh7FFF : -16'sh8000, 16'd4000, 1'b1, 15'd16384);
    // writes outside the register map change nothing
    wait_drained();
    apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF, rd);
    send_request(16'sh1234, 16'd5000, 1'b1, 15'd2048);
  endtask

  task automatic test_latency_extremes();
    set_latency(64);               // period clamp falls below its lower bound
    send_request(16'sh7FFF, 16'hFFFF, 1'b1, 15'd3000);
    random_run(60);
    set_latency(4095);
    send_request(-16'sh8000, 16'hFFFF, 1'b1, 15'd6000);
    random_run(60);
  endtask

  task automatic test_flow_control();
    set_latency(300);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_run(250);
    set_latency(1000);
    send_idle_pct = 54; recv_stall_pct = 0;  random_run(200);
    set_latency(2048);
    send_idle_pct = 0;  recv_stall_pct = 54; random_run(200);
    set_latency(150);
    send_idle_pct = 13; recv_stall_pct = 13; random_run(200);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3000;
    random_run(40);
    wait_drained();
    random_run(40);
  endtask

  initial begin
    for (int i = 0; i < RING; i++) begin
      ring_mem[i] = 0;
      ola_mem[i] = 0;
    end
    win_half = 0;
    wr_pos = START_OFFSET_DEF;
    rd_pos = START_OFFSET_DEF;
    grain_ctr = longint'(START_OFFSET_DEF) << 16;
    mark_pos = grain_ctr;
    period_q6 = PERIOD_RESET;
    ratio_sm = RATIO_ONE;
    ratio_goal = RATIO_ONE;
    voiced_q = 1'b0;
    lat_cfg = LAT_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_latency_extremes();
    test_flow_control();
    test_backpressure();

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
